// ===== rtl/mawst_pkg.sv =====
// ----------------------------------------------------------------------------
// mawst_pkg
// Shared types and constants for the converter moving-average and window
// statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package mawst_pkg;

  localparam int WINDOW_DEF = 10;

  localparam int CODE_W = 12;
  localparam int VAL_W  = 16;
  localparam int TOT_W  = 16;
  localparam int SUM_W  = 28;
  localparam int CNT_W  = 16;
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;
  localparam int FRAC_W = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] adc_code;
    logic              link_up;
  } in_item_t;

  typedef struct packed {
    logic              is_report;
    logic              report_valid;
    logic [CODE_W-1:0] latest_code;
    logic [VAL_W-1:0]  smoothed_value;
    logic [CODE_W-1:0] min_code;
    logic [CODE_W-1:0] max_code;
    logic [VAL_W-1:0]  mean_value;
    logic [CNT_W-1:0]  agg_samples;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_TOT,
    ST_SM_GO,
    ST_SM_WAIT,
    ST_MN_GO,
    ST_MN_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic wr;
    logic upd;
  } ring_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/mawst_div.sv =====
// ----------------------------------------------------------------------------
// mawst_div
// Shared restoring divider, one quotient bit per cycle. The quotient is
// known to fit in 16 bits (upper dividend half below the divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module mawst_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire mawst_pkg::div_req_t            req,
  output logic                                done,
  output logic [mawst_pkg::DIV_DW-1:0]        quotient
);

  localparam int DW = mawst_pkg::DIV_DW;
  localparam int CW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW:0]   trial;
  logic          qbit;

  assign trial = {rem_r, quo_r[DW-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW - 1);
      rem_nxt  = req.dividend[2*DW-1:DW];
      quo_nxt  = req.dividend[DW-1:0];
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
      quo_nxt = {quo_r[DW-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/mawst_ring.sv =====
// ----------------------------------------------------------------------------
// mawst_ring
// Ring of the last WINDOW sample codes with running total and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module mawst_ring #(
  parameter int WINDOW = mawst_pkg::WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire mawst_pkg::ring_ctl_t              ctl,
  input  wire logic [mawst_pkg::CODE_W-1:0]      code,
  output logic [mawst_pkg::TOT_W-1:0]            total,
  output logic [$clog2(WINDOW+1)-1:0]            fill
);

  localparam int CW    = mawst_pkg::CODE_W;
  localparam int TW    = mawst_pkg::TOT_W;
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [CW-1:0] store [WINDOW];
  logic [CW-1:0] old_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          full;

  assign full = (fill_r >= FW'(WINDOW));

  // read-before-write: old_r gets the entry being replaced
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      old_r        <= store[pos_r];
      store[pos_r] <= code;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    fill_nxt  = fill_r;
    total_nxt = total_r;
    if (ctl.upd) begin
      total_nxt = total_r + TW'(code) - (full ? TW'(old_r) : '0);
      if (!full) begin
        fill_nxt = fill_r + 1'b1;
      end
      pos_nxt = (pos_r == PW'(WINDOW - 1)) ? '0 : PW'(pos_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      fill_r  <= '0;
      total_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end
  end

  assign total = total_r;
  assign fill  = fill_r;

endmodule

`default_nettype wire

// ===== rtl/adc_moving_average_window_stats_top.sv =====
// ----------------------------------------------------------------------------
// adc_moving_average_window_stats_top
// Converter sample moving average with min, max, mean and count aggregate.
// ----------------------------------------------------------------------------
// sample: accept, ring write, ring total, then two passes through the shared
//   divider (window average, then aggregate mean), then the output state
// report tick: straight from accept to the output state, mean is kept precomputed
// one transaction in flight: the next accept waits until the output state is left
// synchronous active-low reset clears control, ring pointers and aggregate;
//   the sample ring itself is not cleared and needs no clearing pass
`default_nettype none

module adc_moving_average_window_stats_top #(
  parameter int WINDOW = mawst_pkg::WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire mawst_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output mawst_pkg::out_item_t       out_data
);

  localparam int CW = mawst_pkg::CODE_W;
  localparam int VW = mawst_pkg::VAL_W;
  localparam int SW = mawst_pkg::SUM_W;
  localparam int NW = mawst_pkg::CNT_W;
  localparam int FW = $clog2(WINDOW + 1);

  mawst_pkg::state_t    state_r, state_nxt;
  mawst_pkg::in_item_t  item_r;
  mawst_pkg::out_item_t out_data_r, out_data_nxt;
  mawst_pkg::ring_ctl_t ring_ctl;
  mawst_pkg::div_req_t  div_req;

  logic                 out_valid_r, out_valid_nxt;
  logic                 accept, out_load, div_done;
  logic [VW-1:0]        quotient;
  logic [mawst_pkg::TOT_W-1:0] win_total;
  logic [FW-1:0]        win_fill;

  logic          present_r;
  logic [CW-1:0] latest_r, low_r, high_r;
  logic [VW-1:0] smooth_r, mean_r;
  logic [SW-1:0] sum_r;
  logic [NW-1:0] count_r;
  logic          rep_ok;

  mawst_ring #(.WINDOW(WINDOW)) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .code  (item_r.adc_code),
    .total (win_total),
    .fill  (win_fill)
  );

  mawst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  assign accept = in_valid && !in_stall;
  assign rep_ok = item_r.link_up && present_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mawst_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.kind == mawst_pkg::KIND_REPORT) ? mawst_pkg::ST_OUT
                                                               : mawst_pkg::ST_WR;
        end
      end
      mawst_pkg::ST_WR:      state_nxt = mawst_pkg::ST_TOT;
      mawst_pkg::ST_TOT:     state_nxt = mawst_pkg::ST_SM_GO;
      mawst_pkg::ST_SM_GO:   state_nxt = mawst_pkg::ST_SM_WAIT;
      mawst_pkg::ST_SM_WAIT: if (div_done) state_nxt = mawst_pkg::ST_MN_GO;
      mawst_pkg::ST_MN_GO:   state_nxt = mawst_pkg::ST_MN_WAIT;
      mawst_pkg::ST_MN_WAIT: if (div_done) state_nxt = mawst_pkg::ST_OUT;
      mawst_pkg::ST_OUT:     if (!out_valid_r || !out_stall) state_nxt = mawst_pkg::ST_IDLE;
      default:               state_nxt = mawst_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall         = 1'b1;
    ring_ctl         = '0;
    div_req          = '0;
    out_load         = 1'b0;
    unique case (state_r)
      mawst_pkg::ST_IDLE:  in_stall = 1'b0;
      mawst_pkg::ST_WR:    ring_ctl.wr = 1'b1;
      mawst_pkg::ST_TOT:   ring_ctl.upd = 1'b1;
      mawst_pkg::ST_SM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {{(mawst_pkg::DIV_NW - mawst_pkg::TOT_W - mawst_pkg::FRAC_W){1'b0}},
                            win_total, {mawst_pkg::FRAC_W{1'b0}}};
        div_req.divisor  = mawst_pkg::DIV_DW'(win_fill);
      end
      mawst_pkg::ST_MN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {sum_r, {mawst_pkg::FRAC_W{1'b0}}};
        div_req.divisor  = count_r;
      end
      mawst_pkg::ST_SM_WAIT, mawst_pkg::ST_MN_WAIT: ;
      mawst_pkg::ST_OUT:   out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  // result payload
  always_comb begin
    out_data_nxt = '0;
    if (item_r.kind == mawst_pkg::KIND_REPORT) begin
      out_data_nxt.is_report = 1'b1;
    end
    if (item_r.kind == mawst_pkg::KIND_SAMPLE || rep_ok) begin
      out_data_nxt.report_valid   = (item_r.kind == mawst_pkg::KIND_REPORT);
      out_data_nxt.latest_code    = latest_r;
      out_data_nxt.smoothed_value = smooth_r;
      out_data_nxt.min_code       = low_r;
      out_data_nxt.max_code       = high_r;
      out_data_nxt.mean_value     = mean_r;
      out_data_nxt.agg_samples    = count_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mawst_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      present_r   <= 1'b0;
      latest_r    <= '0;
      smooth_r    <= '0;
      low_r       <= '0;
      high_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      mean_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == mawst_pkg::ST_TOT) begin
        latest_r <= item_r.adc_code;
        if (!present_r) begin
          present_r <= 1'b1;
          low_r     <= item_r.adc_code;
          high_r    <= item_r.adc_code;
          sum_r     <= SW'(item_r.adc_code);
          count_r   <= NW'(1);
        end else begin
          if (item_r.adc_code < low_r) low_r <= item_r.adc_code;
          if (item_r.adc_code > high_r) high_r <= item_r.adc_code;
          // count saturated: total and count hold so the mean stays put
          if (count_r != mawst_pkg::CNT_MAX) begin
            sum_r   <= sum_r + SW'(item_r.adc_code);
            count_r <= count_r + 1'b1;
          end
        end
      end
      if (state_r == mawst_pkg::ST_SM_WAIT && div_done) begin
        smooth_r <= quotient;
      end
      if (state_r == mawst_pkg::ST_MN_WAIT && div_done) begin
        mean_r <= quotient;
      end
      // a valid report empties the aggregate
      if (out_load && item_r.kind == mawst_pkg::KIND_REPORT && rep_ok) begin
        present_r <= 1'b0;
        latest_r  <= '0;
        smooth_r  <= '0;
        low_r     <= '0;
        high_r    <= '0;
        sum_r     <= '0;
        count_r   <= '0;
        mean_r    <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== tb/adc_moving_average_window_stats_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_moving_average_window_stats_top_tb
// Self-checking bench for the converter moving-average and statistics block.
// A scoreboard keeps its own copy of the sample ring and the report aggregate.
// It predicts every result and compares it field by field with the block's
// output. The stimulus is a directed opening, then a long run with no idling,
// then random sample and report traffic. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------

module adc_moving_average_window_stats_top_tb;

  localparam int WIN         = mawst_pkg::WINDOW_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1520;
  localparam int STEADY_ITEMS = 200;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_PRINTED = 40;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  mawst_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  mawst_pkg::out_item_t out_data;
  logic                 steady    = 1'b0;
  int unsigned          quiet_cycles = 0;

  class stats_scoreboard;
    mawst_pkg::out_item_t expected_stats[$];
    logic [11:0] ring [WIN];
    int unsigned ring_pos    = 0;
    int unsigned ring_fill   = 0;
    logic [15:0] ring_sum    = '0;
    logic        agg_valid   = 1'b0;
    logic [11:0] last_code   = '0;
    logic [15:0] last_smooth = '0;
    logic [11:0] low_code    = '0;
    logic [11:0] high_code   = '0;
    logic [27:0] code_sum    = '0;
    logic [15:0] code_count  = '0;
    int          errors      = 0;
    int          checked     = 0;

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", what);
    endtask

    function logic [15:0] aggregate_mean();
      logic [31:0] q;
      if (code_count == 16'd0) return 16'd0;
      q = {code_sum, 4'b0000} / {16'd0, code_count};
      return q[15:0];
    endfunction

    function void clear_aggregate();
      agg_valid   = 1'b0;
      last_code   = '0;
      last_smooth = '0;
      low_code    = '0;
      high_code   = '0;
      code_sum    = '0;
      code_count  = '0;
    endfunction

    task note_input(mawst_pkg::in_item_t item);
      mawst_pkg::out_item_t r;
      logic [31:0] q;
      r = '0;
      if (item.kind == mawst_pkg::KIND_SAMPLE) begin
        // oldest entry leaves the ring only once it is full
        if (ring_fill < WIN) begin
          ring_fill++;
        end else begin
          ring_sum = ring_sum - {4'b0000, ring[ring_pos]};
        end
        ring[ring_pos] = item.adc_code;
        ring_sum = ring_sum + {4'b0000, item.adc_code};
        ring_pos = (ring_pos + 1) % WIN;
        q = {12'd0, ring_sum, 4'b0000} / ring_fill;
        last_smooth = q[15:0];
        if (!agg_valid) begin
          agg_valid  = 1'b1;
          low_code   = item.adc_code;
          high_code  = item.adc_code;
          code_sum   = {16'd0, item.adc_code};
          code_count = 16'd1;
        end else begin
          if (item.adc_code < low_code) low_code = item.adc_code;
          if (item.adc_code > high_code) high_code = item.adc_code;
          // total and count freeze together once the count saturates
          if (code_count != mawst_pkg::CNT_MAX) begin
            code_sum   = code_sum + {16'd0, item.adc_code};
            code_count = code_count + 16'd1;
          end
        end
        last_code = item.adc_code;
        r.latest_code    = last_code;
        r.smoothed_value = last_smooth;
        r.min_code       = low_code;
        r.max_code       = high_code;
        r.mean_value     = aggregate_mean();
        r.agg_samples    = code_count;
      end else begin
        r.is_report = 1'b1;
        if (item.link_up && agg_valid) begin
          r.report_valid   = 1'b1;
          r.latest_code    = last_code;
          r.smoothed_value = last_smooth;
          r.min_code       = low_code;
          r.max_code       = high_code;
          r.mean_value     = aggregate_mean();
          r.agg_samples    = code_count;
          clear_aggregate();
        end
      end
      expected_stats.push_back(r);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                  checked, name, got, want));
      end
    endtask

    task check_result(mawst_pkg::out_item_t got);
      mawst_pkg::out_item_t want;
      if (expected_stats.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", checked));
        checked++;
        return;
      end
      want = expected_stats.pop_front();
      compare_field("is_report", 16'(got.is_report), 16'(want.is_report));
      compare_field("report_valid", 16'(got.report_valid), 16'(want.report_valid));
      compare_field("latest_code", 16'(got.latest_code), 16'(want.latest_code));
      compare_field("smoothed_value", got.smoothed_value, want.smoothed_value);
      compare_field("min_code", 16'(got.min_code), 16'(want.min_code));
      compare_field("max_code", 16'(got.max_code), 16'(want.max_code));
      compare_field("mean_value", got.mean_value, want.mean_value);
      compare_field("agg_samples", got.agg_samples, want.agg_samples);
      checked++;
    endtask
  endclass

  stats_scoreboard sb;

  adc_moving_average_window_stats_top #(
    .WINDOW(WIN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check each accepted transaction, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= rst_n && !steady && ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [11:0] pick_code();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return 12'h000;
    if (sel < 20) return 12'hFFF;
    if (sel < 35) return 12'($urandom_range(15));
    return 12'($urandom_range(4095));
  endfunction

  task automatic push_item(input logic kind, input logic [11:0] code, input logic link);
    mawst_pkg::in_item_t item;
    item.kind     = kind;
    item.adc_code = code;
    item.link_up  = link;
    while (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_input(item);
  endtask

  task automatic push_sample(input logic [11:0] code);
    push_item(mawst_pkg::KIND_SAMPLE, code, 1'($urandom_range(1)));
  endtask

  task automatic push_tick(input logic link);
    push_item(mawst_pkg::KIND_REPORT, 12'($urandom_range(4095)), link);
  endtask

  initial begin
    int unsigned sel;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // report ticks with no samples yet, then two samples, a link-down tick, a valid report and an empty one
    push_tick(1'b1);
    push_tick(1'b0);
    push_item(mawst_pkg::KIND_SAMPLE, 12'h000, 1'b1);
    push_item(mawst_pkg::KIND_SAMPLE, 12'hFFF, 1'b0);
    push_tick(1'b0);
    push_tick(1'b1);
    push_tick(1'b1);
    // fill the window and wrap around it
    push_sample(12'd1);
    push_sample(12'd2);
    push_sample(12'hFFF);
    push_sample(12'hFFF);
    push_sample(12'd100);
    push_sample(12'h800);
    push_sample(12'h000);
    push_sample(12'hFFF);
    push_sample(12'd7);
    push_sample(12'd3000);
    push_sample(12'hFFF);
    push_sample(12'd5);
    push_item(mawst_pkg::KIND_REPORT, 12'hFFF, 1'b1);

    // long run with no idling on either side
    steady = 1'b1;
    for (int n = 0; n < STEADY_ITEMS; n++) push_sample(pick_code());
    push_tick(1'b0);
    push_sample(12'hFFF);
    push_tick(1'b1);
    steady = 1'b0;

    // random traffic: mostly samples, report ticks now and then
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(99);
      if (sel < 85) begin
        push_sample(pick_code());
      end else begin
        push_tick($urandom_range(99) < 75);
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_stats.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
